@@ src/lds_pkg.sv @@
// shared types, constants and the quarter-wave sine table for the lissajous generator
// no dependencies; imported by every module of the block
package lds_pkg;

    localparam int PHASE_BITS = 32;
    localparam int TABLE_BITS = 10;
    localparam int TAB_N      = 1 << TABLE_BITS;
    localparam int ADDR_W     = TABLE_BITS + 1;
    localparam int MAG_W      = 15;
    localparam int RATIO_W    = 4;
    localparam int OFFSET_W   = 16;
    localparam int DEPTH_W    = 10;
    localparam int SPEED_W    = 13;
    localparam int OUT_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // shared multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 13;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int AMP_W   = MAG_W + DEPTH_W;

    // output scaling
    localparam int NUM_W = 26;
    localparam logic [NUM_W-1:0] MID_NUM = NUM_W'(1023 * 32768);

    // phase increment
    localparam logic [MUL_A_W-1:0] INC_KQ    = 33'd5473867779;
    localparam int                 INC_SHIFT = 48 - PHASE_BITS;
    localparam logic [PHASE_BITS-1:0] INC_HI = PHASE_BITS'(64'd682881710 >> (32 - PHASE_BITS));
    localparam logic [PHASE_BITS-1:0] INC_LO = PHASE_BITS'(64'd68357 >> (32 - PHASE_BITS));
    localparam logic [SPEED_W-1:0] SPEED_CAP = SPEED_W'(8184);

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_RATIO  = 2'd0,
        CFG_Y_RATIO  = 2'd1,
        CFG_X_OFFSET = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XARG,
        ST_YARG,
        ST_XAMP,
        ST_YAMP,
        ST_INC,
        ST_PHASE,
        ST_WAIT,
        ST_XCAP,
        ST_YCAP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             neg;
        logic [AMP_W-1:0] amp;
    } t_scale_req;

    typedef logic [MAG_W-1:0] t_tab [0:TAB_N];

    // quarter sine in q15, integer taylor series in q30, evaluated at elaboration
    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      q;
        for (int i = 0; i <= TAB_N; i++) begin
            x    = (64'(i) * PI_HALF_Q30) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) != 0) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            q = (sum + 64'sd16384) >>> 15;
            if (q > 32767) begin
                q = 32767;
            end
            tab[i] = MAG_W'(q);
        end
        return tab;
    endfunction

    localparam t_tab QUARTER_TAB = build_tab();

endpackage

@@ src/lds_mul.sv @@
// shared unsigned multiplier with registered product
// depends on lds_pkg
module lds_mul import lds_pkg::*; (
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

@@ src/lds_rom.sv @@
// quarter-wave sine rom, one registered read port
// depends on lds_pkg for the table contents
module lds_rom import lds_pkg::*; (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_addr,
    output logic [MAG_W-1:0]  o_data
);

    logic [MAG_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= QUARTER_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

@@ src/lds_scale.sv @@
// four-stage pipeline: signed amplitude product to dac code, floor of num*65535/(2046*32768)
// depends on lds_pkg
module lds_scale import lds_pkg::*; (
    input  logic             i_clk,
    input  t_scale_req       i_req,
    output logic [OUT_W-1:0] o_code
);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_m;
    logic [NUM_W-1:0] r_m3;
    logic [16:0]      r_q0;
    logic [OUT_W-1:0] r_code;

    logic [36:0] m_1025;
    logic [26:0] q_1023;
    logic [26:0] rem;

    // num*65535 >> 16 == num - ceil(num / 65536)
    always_ff @(posedge i_clk) begin
        r_num <= i_req.neg ? MID_NUM - NUM_W'(i_req.amp) : MID_NUM + NUM_W'(i_req.amp);
        r_m   <= r_num - NUM_W'((27'(r_num) + 27'd65535) >> 16);
        r_m3  <= r_m;
        r_q0  <= m_1025[36:20];
        r_code <= (rem >= 27'd1023) ? OUT_W'(r_q0 + 17'd1) : OUT_W'(r_q0);
    end

    // 1025 / 2^20 underestimates 1/1023 by at most one unit after the floor
    assign m_1025 = {1'b0, r_m, 10'b0} + 37'(r_m);
    assign q_1023 = {r_q0, 10'b0} - 27'(r_q0);
    assign rem    = 27'(r_m3) - q_1023;

    assign o_code = r_code;

endmodule

@@ src/lissajous_dual_sine_generator_unit.sv @@
// top level of the lissajous dual sine generator: sequencer, phase and config registers
// depends on lds_pkg, lds_mul, lds_rom and lds_scale
//
// Each input beat (x depth, y depth, speed) produces one output beat holding the x and
// y dac codes computed from the current phase, after which the 32-bit turn accumulator
// advances by speed/8184 rad (clamped to 0.0001..0.999 rad). The sequencer is serial
// because of the shared unit: every product (ratio times phase for each channel, sine
// magnitude times depth for each channel, and the speed increment) goes through one
// shared 33x13 multiplier in turn, and the dac scaling runs through a four-stage
// pipeline that both channels share. The sine comes from a 1025-entry quarter-wave rom
// with a registered read. The input is stalled from acceptance until the output beat
// is taken, so an output stall also holds off the next item. Configuration writes are
// taken at any time but are meant to land only while the block is idle; writes to an
// unknown index are dropped. No clearing pass is needed after reset.
module lissajous_dual_sine_generator_unit import lds_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [DEPTH_W-1:0]   i_x_depth,
    input  logic [DEPTH_W-1:0]   i_y_depth,
    input  logic [SPEED_W-1:0]   i_speed,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_x_out,
    output logic [OUT_W-1:0]     o_y_out,
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // control state
    t_state                  r_state;
    t_state                  n_state;
    logic                    r_valid;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [RATIO_W-1:0]      r_x_ratio;
    logic [RATIO_W-1:0]      r_y_ratio;
    logic [OFFSET_W-1:0]     r_x_offset;

    // payload
    logic [DEPTH_W-1:0]      r_x_depth;
    logic [DEPTH_W-1:0]      r_y_depth;
    logic [SPEED_W-1:0]      r_speed;
    logic                    r_x_neg;
    logic                    r_y_neg;
    logic [OUT_W-1:0]        r_x_out;
    logic [OUT_W-1:0]        r_y_out;

    // datapath glue
    t_mul_req                mul_req;
    logic [PROD_W-1:0]       mul_prod;
    logic [ADDR_W-1:0]       rom_addr;
    logic [MAG_W-1:0]        rom_data;
    t_scale_req              scale_req;
    logic [OUT_W-1:0]        scale_code;
    logic [PHASE_BITS-1:0]   arg_add;
    logic [PHASE_BITS-1:0]   arg;
    logic [1:0]              quad;
    logic [TABLE_BITS-1:0]   idx;
    logic [PHASE_BITS-1:0]   inc;
    logic                    in_beat;
    logic                    out_beat;

    assign in_beat  = i_valid && !o_stall;
    assign out_beat = r_valid && !i_stall;

    lds_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    lds_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    lds_scale u_scale (
        .i_clk  (i_clk),
        .i_req  (scale_req),
        .o_code (scale_code)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_XARG;
            ST_XARG:  n_state = ST_YARG;
            ST_YARG:  n_state = ST_XAMP;
            ST_XAMP:  n_state = ST_YAMP;
            ST_YAMP:  n_state = ST_INC;
            ST_INC:   n_state = ST_PHASE;
            ST_PHASE: n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_XCAP;
            ST_XCAP:  n_state = ST_YCAP;
            ST_YCAP:  n_state = ST_OUT;
            ST_OUT:   if (!i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // table address: the x argument carries the offset, quadrant folds the index
    assign arg_add = (r_state == ST_YARG) ? PHASE_BITS'(r_x_offset) << (PHASE_BITS - OFFSET_W)
                                          : '0;
    assign arg     = mul_prod[PHASE_BITS-1:0] + arg_add;
    assign quad    = arg[PHASE_BITS-1 -: 2];
    assign idx     = arg[PHASE_BITS-3 -: TABLE_BITS];
    assign rom_addr = quad[0] ? ADDR_W'(TAB_N) - ADDR_W'(idx) : ADDR_W'(idx);

    // shared unit operand select and scaler feed
    always_comb begin
        mul_req   = '0;
        scale_req = '0;
        unique case (r_state)
            ST_XARG: begin
                mul_req.a = MUL_A_W'(r_phase);
                mul_req.b = MUL_B_W'(r_x_ratio);
            end
            ST_YARG: begin
                mul_req.a = MUL_A_W'(r_phase);
                mul_req.b = MUL_B_W'(r_y_ratio);
            end
            ST_XAMP: begin
                mul_req.a = MUL_A_W'(rom_data);
                mul_req.b = MUL_B_W'(r_x_depth);
            end
            ST_YAMP: begin
                mul_req.a     = MUL_A_W'(rom_data);
                mul_req.b     = MUL_B_W'(r_y_depth);
                scale_req.neg = r_x_neg;
                scale_req.amp = mul_prod[AMP_W-1:0];
            end
            ST_INC: begin
                mul_req.a     = INC_KQ;
                mul_req.b     = r_speed;
                scale_req.neg = r_y_neg;
                scale_req.amp = mul_prod[AMP_W-1:0];
            end
            default: begin
                mul_req   = '0;
                scale_req = '0;
            end
        endcase
    end

    // phase increment, clamped at both ends
    always_comb begin
        if (r_speed >= SPEED_CAP) begin
            inc = INC_HI;
        end else if (r_speed == '0) begin
            inc = INC_LO;
        end else begin
            inc = PHASE_BITS'(mul_prod >> INC_SHIFT);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= 1'b0;
            r_phase    <= '0;
            r_x_ratio  <= RATIO_W'(1);
            r_y_ratio  <= RATIO_W'(2);
            r_x_offset <= OFFSET_W'(16384);
        end else begin
            r_state <= n_state;
            if (r_state == ST_YCAP) begin
                r_valid <= 1'b1;
            end else if (out_beat) begin
                r_valid <= 1'b0;
            end
            if (r_state == ST_PHASE) begin
                r_phase <= r_phase + inc;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_X_RATIO:  r_x_ratio  <= i_cfg_data[RATIO_W-1:0];
                    CFG_Y_RATIO:  r_y_ratio  <= i_cfg_data[RATIO_W-1:0];
                    CFG_X_OFFSET: r_x_offset <= i_cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_x_depth <= i_x_depth;
            r_y_depth <= i_y_depth;
            r_speed   <= i_speed;
        end
        if (r_state == ST_YARG) begin
            r_x_neg <= quad[1];
        end
        if (r_state == ST_XAMP) begin
            r_y_neg <= quad[1];
        end
        // scaler latency puts x at its output in xcap and y in ycap
        if (r_state == ST_XCAP) begin
            r_x_out <= scale_code;
        end
        if (r_state == ST_YCAP) begin
            r_y_out <= scale_code;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_x_out = r_x_out;
    assign o_y_out = r_y_out;

    // busy right after taking a beat
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_stall)
        else $error("input taken while sequencer was not started");

    // a pending result keeps the input side closed
    a_valid_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> o_stall)
        else $error("result pending while input open");

    // one result per item
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |=> !r_valid)
        else $error("result repeated");

    // the accumulator moves only in its update step
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_PHASE) |=> $stable(r_phase))
        else $error("phase changed outside update step");

    // codes stay under full scale
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_x_out != '1) && (r_y_out != '1))
        else $error("dac code at full scale");

endmodule

@@ verif/lissajous_dual_sine_generator_unit_test.sv @@
`timescale 1ns / 100ps
// self-checking bench for lissajous_dual_sine_generator_unit: random and directed ticks
// against a scoreboard that predicts both dac codes; depends on lds_pkg and the rtl only
module lissajous_dual_sine_generator_unit_test;
    import lds_pkg::*;

    // timing of the bench
    localparam int CLK_HALF_NS  = 6;
    localparam int SETTLE_CYC   = 24;
    localparam int DRAIN_CYC    = 5000;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int IDLE_PCT     = 32;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_TICKS  = 192;

    // arithmetic of the generator
    localparam int          SINE_STEPS = 1024;   // quarter-wave table spacing
    localparam int          DEPTH_FULL = 1023;
    localparam longint      Q15_ONE    = 32768;
    localparam longint      DAC_FULL   = 65535;
    localparam logic [63:0] QTR_PI_Q30 = 64'd1686629713;   // pi/2 in q30
    localparam logic [63:0] RAD_STEP_K = 64'd5473867779;   // 2^48 / (8184 * 2 * pi)
    localparam logic [31:0] STEP_MAX   = 32'd682881710;    // 0.999 rad in turn units
    localparam logic [31:0] STEP_MIN   = 32'd68357;        // 0.0001 rad in turn units
    localparam int          SPEED_TOP  = 8184;

    // the one index the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] x_code;
        logic [OUT_W-1:0] y_code;
    } t_dac_pair;

    // scoreboard: keeps its own phase and registers, predicts the codes of each tick
    class dac_scoreboard;
        logic [MAG_W-1:0]    quarter_sine [0:SINE_STEPS];
        logic [RATIO_W-1:0]  x_ratio;
        logic [RATIO_W-1:0]  y_ratio;
        logic [OFFSET_W-1:0] x_offset;
        logic [31:0]         phase_acc;
        t_dac_pair           pending_codes [$];
        int unsigned         mismatches;

        function new();
            logic [63:0] ang;
            logic [63:0] ang_sq;
            logic [63:0] term;
            logic [63:0] div;
            longint      acc;
            longint      rounded;
            // sine quarter wave in q15 from an eight-term taylor series in q30
            for (int i = 0; i <= SINE_STEPS; i++) begin
                ang    = (64'(i) * QTR_PI_Q30) >> 10;
                ang_sq = (ang * ang) >> 30;
                term   = ang;
                acc    = longint'(ang);
                for (int k = 1; k <= 7; k++) begin
                    div  = 64'((2 * k) * (2 * k + 1));
                    term = ((term * ang_sq) >> 30) / div;
                    acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
                end
                if (acc < 0) begin
                    acc = 0;
                end
                rounded = (acc + 16384) >>> 15;
                quarter_sine[i] = MAG_W'((rounded > 32767) ? 32767 : rounded);
            end
            x_ratio     = 4'd1;
            y_ratio     = 4'd2;
            x_offset    = 16'd16384;
            phase_acc   = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_X_RATIO: begin
                    x_ratio = data[RATIO_W-1:0];
                end
                CFG_Y_RATIO: begin
                    y_ratio = data[RATIO_W-1:0];
                end
                CFG_X_OFFSET: begin
                    x_offset = data[OFFSET_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // signed q15 sine, quadrant folded from the quarter table
        function int sine_at(logic [31:0] arg);
            logic [1:0] quad;
            int         idx;
            int         mag;
            quad = arg[31:30];
            idx  = int'(arg[29:20]);
            mag  = quad[0] ? int'(quarter_sine[SINE_STEPS - idx]) : int'(quarter_sine[idx]);
            return quad[1] ? -mag : mag;
        endfunction

        function logic [OUT_W-1:0] dac_level(int s, logic [DEPTH_W-1:0] depth);
            longint num;
            num = longint'(DEPTH_FULL) * Q15_ONE + longint'(s) * longint'(depth);
            if (num < 0) begin
                num = 0;
            end
            return OUT_W'((num * DAC_FULL) / (2 * longint'(DEPTH_FULL) * Q15_ONE));
        endfunction

        function logic [31:0] phase_step(logic [SPEED_W-1:0] spd);
            logic [63:0] prod;
            if (int'(spd) >= SPEED_TOP) begin
                return STEP_MAX;
            end
            if (spd == '0) begin
                return STEP_MIN;
            end
            prod = 64'(spd) * RAD_STEP_K;
            return 32'(prod >> 16);
        endfunction

        function void note_tick(logic [DEPTH_W-1:0] xd, logic [DEPTH_W-1:0] yd,
                                logic [SPEED_W-1:0] spd);
            logic [31:0] x_arg;
            logic [31:0] y_arg;
            t_dac_pair   want;
            x_arg = x_ratio * phase_acc + {x_offset, 16'd0};
            y_arg = y_ratio * phase_acc;
            want.x_code = dac_level(sine_at(x_arg), xd);
            want.y_code = dac_level(sine_at(y_arg), yd);
            pending_codes.push_back(want);
            phase_acc = phase_acc + phase_step(spd);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatches++;
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        endtask

        task check_codes(logic [OUT_W-1:0] x_code, logic [OUT_W-1:0] y_code);
            t_dac_pair want;
            if (pending_codes.size() == 0) begin
                report_mismatch("unexpected beat x_out", x_code, 0);
            end else begin
                want = pending_codes.pop_front();
                if (x_code !== want.x_code) begin
                    report_mismatch("x_out", x_code, want.x_code);
                end
                if (y_code !== want.y_code) begin
                    report_mismatch("y_out", y_code, want.y_code);
                end
            end
        endtask
    endclass

    // block ports, inputs at known values from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [DEPTH_W-1:0]   i_x_depth = '0;
    logic [DEPTH_W-1:0]   i_y_depth = '0;
    logic [SPEED_W-1:0]   i_speed = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [OUT_W-1:0]     o_x_out;
    logic [OUT_W-1:0]     o_y_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // when set, neither side idles
    bit calm = 1'b0;

    dac_scoreboard board = new();

    lissajous_dual_sine_generator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_depth  (i_x_depth),
        .i_y_depth  (i_y_depth),
        .i_speed    (i_speed),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_x_out    (o_x_out),
        .o_y_out    (o_y_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // output side: check each taken beat, then pick the stall for the next edge
    // (values read here are the ones that were present just before the edge)
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_codes(o_x_out, o_y_out);
        end
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // one input beat: optional idle gap, then hold valid until the block takes it
    task automatic send_tick(input logic [DEPTH_W-1:0] xd, input logic [DEPTH_W-1:0] yd,
                             input logic [SPEED_W-1:0] spd);
        int unsigned gap;
        gap = (!calm && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_depth <= xd;
        i_y_depth <= yd;
        i_speed   <= spd;
        do @(posedge i_clk); while (o_stall);
        board.note_tick(xd, yd, spd);
    endtask

    // register write; the caller drops the write enable after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    // all three registers, junk in the unused upper bits of the ratio writes, and optionally a stray index
    task automatic apply_config(input logic [RATIO_W-1:0] xr, input logic [RATIO_W-1:0] yr,
                                input logic [OFFSET_W-1:0] off, input bit stray);
        write_reg(CFG_X_RATIO, {12'($urandom), xr});
        write_reg(CFG_Y_RATIO, {12'($urandom), yr});
        write_reg(CFG_X_OFFSET, off);
        if (stray) begin
            write_reg(CFG_SPARE_IDX, 16'($urandom));
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every expected beat, then let the block settle
    task automatic drain();
        int unsigned waited;
        waited = 0;
        i_valid <= 1'b0;
        while (board.pending_codes.size() != 0 && waited < DRAIN_CYC) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // random tick content: mostly full range, some depth extremes, speeds near the cap and near zero
    task automatic send_random_tick();
        logic [DEPTH_W-1:0] xd;
        logic [DEPTH_W-1:0] yd;
        logic [SPEED_W-1:0] spd;
        int unsigned        pick;
        xd   = ($urandom_range(9) < 2) ? ($urandom_range(1) ? 10'd1023 : 10'd0) : 10'($urandom);
        yd   = ($urandom_range(9) < 2) ? ($urandom_range(1) ? 10'd1023 : 10'd0) : 10'($urandom);
        pick = $urandom_range(9);
        if (pick < 2) begin
            spd = 13'($urandom_range(8170, 8191));
        end else if (pick < 3) begin
            spd = 13'($urandom_range(0, 3));
        end else begin
            spd = 13'($urandom);
        end
        send_tick(xd, yd, spd);
    endtask

    initial begin
        logic [RATIO_W-1:0]  xr;
        logic [RATIO_W-1:0]  yr;
        logic [OFFSET_W-1:0] off;

        // synchronous reset, held low from time zero
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset settings: depth extremes, speed floor, cap and either side of it, mixed patterns
        send_tick(10'd0, 10'd0, 13'd0);
        send_tick(10'd1023, 10'd1023, 13'd0);
        send_tick(10'd1023, 10'd1023, 13'd1);
        send_tick(10'd1023, 10'd1023, 13'd8174);
        send_tick(10'd1023, 10'd1023, 13'd8175);
        send_tick(10'd1023, 10'd0, 13'd8183);
        send_tick(10'd0, 10'd1023, 13'd8184);
        send_tick(10'd1023, 10'd1023, 13'd8191);
        send_tick(10'h2AA, 10'h155, 13'h0AAA);
        send_tick(10'h155, 10'h2AA, 13'h1555);
        send_tick(10'd512, 10'd511, 13'd4096);
        // big steps to walk through every quadrant at full swing
        repeat (4) send_tick(10'd1023, 10'd1023, 13'd8191);
        drain();

        // ratio of zero on both channels: arguments stay put, x holds its offset
        apply_config(4'd0, 4'd0, 16'd0, 1'b1);
        send_tick(10'd1023, 10'd1023, 13'd8191);
        send_tick(10'd1023, 10'd1023, 13'd5000);
        send_tick(10'd700, 10'd300, 13'd8191);
        drain();

        // ratios and offset at their tops
        apply_config(4'd15, 4'd15, 16'hFFFF, 1'b0);
        send_tick(10'd1023, 10'd1023, 13'd8191);
        send_tick(10'd1023, 10'd1023, 13'd3);
        send_tick(10'd1023, 10'd1023, 13'd8184);
        send_tick(10'd1, 10'd1, 13'd2047);
        drain();

        // random phases: fixed corner settings first, then random settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    xr = 4'd15; yr = 4'd15; off = 16'hFFFF;
                end
                1: begin
                    xr = 4'd1;  yr = 4'd1;  off = 16'd0;
                end
                2: begin
                    xr = 4'd0;  yr = 4'd15; off = 16'h8000;
                end
                3: begin
                    xr = 4'd15; yr = 4'd0;  off = 16'd1;
                end
                default: begin
                    xr = 4'($urandom); yr = 4'($urandom); off = 16'($urandom);
                end
            endcase
            apply_config(xr, yr, off, p % 2 == 1);
            calm = (p == 5);      // one long stretch with no idling on either side
            repeat (PHASE_TICKS) send_random_tick();
            drain();
            calm = 1'b0;
        end

        // leftover expectations count as failures
        if (board.pending_codes.size() != 0) begin
            board.report_mismatch("beats never seen", 0, board.pending_codes.size());
        end
        if (board.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
